@@ rtl/overwrite_oldest_byte_fifo_macros.svh @@
// Assertion macros for the RTL.
`ifndef OVERWRITE_OLDEST_BYTE_FIFO_MACROS_SVH
`define OVERWRITE_OLDEST_BYTE_FIFO_MACROS_SVH

// Check outside of reset.
`define OOBF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define OOBF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/oobf_pkg.sv @@
`default_nettype none

package oobf_pkg;

  localparam int unsigned Depth  = 4096;
  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned UsedW  = $clog2(Depth + 1);
  localparam int unsigned FillW  = 13;
  localparam int unsigned DataW  = 8;
  localparam int unsigned CountW = 32;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRead  = 2'd1,
    OpTake  = 2'd2,
    OpNop   = 2'd3
  } op_e;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic              read_valid;
    logic              overwrote;
    logic [FillW-1:0]  fill_level;
    logic [CountW-1:0] dropped_taken;
    logic [CountW-1:0] dropped_all;
  } result_t;

  function automatic logic [AddrW-1:0] ptr_next(input logic [AddrW-1:0] p);
    logic [AddrW-1:0] n;
    n = (p == AddrW'(Depth - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    logic [CountW-1:0] n;
    n = (v == '1) ? v : v + 1'b1;
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/oobf_ram.sv @@
`default_nettype none

module oobf_ram #(
  parameter int unsigned RamDepth = 4096,
  parameter int unsigned RamDataW = 8,
  parameter int unsigned RamAddrW = (RamDepth > 1) ? $clog2(RamDepth) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [RamAddrW-1:0] waddr_i,
  input  wire logic [RamDataW-1:0] wdata_i,
  input  wire logic                re_i,
  input  wire logic [RamAddrW-1:0] raddr_i,
  output      logic [RamDataW-1:0] rdata_o
);

  logic [RamDataW-1:0] mem [RamDepth];
  logic [RamDataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/oobf_ctrl.sv @@
`default_nettype none

`include "overwrite_oldest_byte_fifo_macros.svh"

module oobf_ctrl
  import oobf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             acc_i,
  input  wire op_e              op_i,
  input  wire logic [DataW-1:0] data_byte_i,
  output      mem_req_t         mem_o,
  output      result_t          res_o
);

  logic [AddrW-1:0]  head_q, head_d;
  logic [AddrW-1:0]  tail_q, tail_d;
  logic [UsedW-1:0]  used_q, used_d;
  logic [CountW-1:0] since_q, since_d;
  logic [CountW-1:0] total_q, total_d;
  logic              full;
  logic              empty;
  logic              wr_full;
  logic              rd_empty;

  assign full  = (used_q == UsedW'(Depth));
  assign empty = (used_q == '0);

  assign wr_full  = acc_i && (op_i == OpWrite) && full;
  assign rd_empty = acc_i && (op_i == OpRead) && empty;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    used_d  = used_q;
    since_d = since_q;
    total_d = total_q;
    mem_o   = '0;
    res_o   = '0;
    if (acc_i) begin
      case (op_i)
        OpWrite: begin
          if (full) begin
            head_d          = ptr_next(head_q);
            since_d         = sat_inc(since_q);
            total_d         = sat_inc(total_q);
            res_o.overwrote = 1'b1;
          end else begin
            used_d = used_q + 1'b1;
          end
          mem_o.we    = 1'b1;
          mem_o.waddr = tail_q;
          mem_o.wdata = data_byte_i;
          tail_d      = ptr_next(tail_q);
        end
        OpRead: begin
          if (!empty) begin
            mem_o.re         = 1'b1;
            mem_o.raddr      = head_q;
            res_o.read_valid = 1'b1;
            head_d           = ptr_next(head_q);
            used_d           = used_q - 1'b1;
          end
        end
        OpTake: begin
          since_d = '0;
        end
        default: begin
        end
      endcase
    end
    res_o.fill_level    = FillW'(used_d);
    res_o.dropped_taken = (op_i == OpTake) ? since_q : since_d;
    res_o.dropped_all   = total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      used_q  <= '0;
      since_q <= '0;
      total_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      used_q  <= used_d;
      since_q <= since_d;
      total_q <= total_d;
    end
  end

  `OOBF_ASSERT(a_used_bound, used_q <= UsedW'(Depth), "fill count above depth")
  `OOBF_ASSERT(a_drop_order, since_q <= total_q, "drop count above total")
  `OOBF_ASSERT(a_full_write, wr_full |=> full, "full write changed fill")
  `OOBF_ASSERT(a_empty_read, rd_empty |=> ($stable(head_q) && empty), "empty read moved state")

endmodule

`default_nettype wire

@@ rtl/overwrite_oldest_byte_fifo.sv @@
// Byte FIFO that never refuses a write: a write into a full store drops
// the oldest byte and counts the drop.
// Input channel: in_valid_i / in_stall_o with op_i and data_byte_i.
//   op 0 writes a byte, op 1 pops the oldest byte, op 2 returns and
//   clears the dropped-since-take count, op 3 only reports status.
// Output channel: out_valid_o / out_stall_i, one result per transfer in,
//   carrying the popped byte, the fill level and both drop counters.
// Latency: a result is valid the cycle after its input transfer.
// Throughput: one item per cycle while in_stall_o is low; each item makes at most
//   one store access, a write or a read, along with its pointer updates.
// A stalled result holds in the output register, and in_stall_o stays
//   high until it is taken.
// Reset clears pointers, fill level and counters at once; store contents
//   are not cleared and are only read after being written.
`default_nettype none

module overwrite_oldest_byte_fifo
  import oobf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [7:0]        data_byte_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [7:0]        read_data_o,
  output      logic              read_valid_o,
  output      logic              overwrote_o,
  output      logic [FillW-1:0]  fill_level_o,
  output      logic [CountW-1:0] dropped_taken_o,
  output      logic [CountW-1:0] dropped_all_o
);

  logic             acc;
  logic             out_valid_q, out_valid_d;
  result_t          res;
  result_t          res_q;
  mem_req_t         mem_req;
  logic [DataW-1:0] rdata;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  oobf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .op_i        (op_e'(op_i)),
    .data_byte_i (data_byte_i),
    .mem_o       (mem_req),
    .res_o       (res)
  );

  oobf_ram #(
    .RamDepth (Depth),
    .RamDataW (DataW),
    .RamAddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  assign out_valid_d = acc || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = res_q.read_valid ? rdata : '0;
  assign read_valid_o    = res_q.read_valid;
  assign overwrote_o     = res_q.overwrote;
  assign fill_level_o    = res_q.fill_level;
  assign dropped_taken_o = res_q.dropped_taken;
  assign dropped_all_o   = res_q.dropped_all;

endmodule

`default_nettype wire

@@ tb/sv/overwrite_oldest_byte_fifo_tb.sv @@
`default_nettype none

module overwrite_oldest_byte_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import oobf_pkg::*;

  localparam int unsigned HalfPeriod  = 5;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MixedItems  = 300;
  localparam int unsigned OverItems   = 350;
  localparam int unsigned DrainItems  = 280;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned ReportMax   = 10;

  typedef struct packed {
    logic [DataW-1:0]  read_data;
    logic              read_valid;
    logic              overwrote;
    logic [FillW-1:0]  fill_level;
    logic [CountW-1:0] dropped_taken;
    logic [CountW-1:0] dropped_all;
  } fifo_status_t;

  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] data;
    logic             known;
    fifo_status_t     status;
  } script_row_t;

  localparam fifo_status_t NoStatus = '0;

  // known = 1: status typed in; known = 0: status from the predictor
  localparam script_row_t Script [19] = '{
    '{OpRead,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd0, 32'd0, 32'd0}},
    '{OpTake,  8'hff, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd0, 32'd0, 32'd0}},
    '{OpNop,   8'hff, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd0, 32'd0, 32'd0}},
    '{OpWrite, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd1, 32'd0, 32'd0}},
    '{OpWrite, 8'hff, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd2, 32'd0, 32'd0}},
    '{OpNop,   8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd2, 32'd0, 32'd0}},
    '{OpRead,  8'hff, 1'b1, '{8'h00, 1'b1, 1'b0, 13'd1, 32'd0, 32'd0}},
    '{OpRead,  8'h00, 1'b1, '{8'hff, 1'b1, 1'b0, 13'd0, 32'd0, 32'd0}},
    '{OpRead,  8'h5a, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd0, 32'd0, 32'd0}},
    '{OpWrite, 8'h80, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd1, 32'd0, 32'd0}},
    '{OpWrite, 8'h7f, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd2, 32'd0, 32'd0}},
    '{OpWrite, 8'h01, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd3, 32'd0, 32'd0}},
    '{OpTake,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd3, 32'd0, 32'd0}},
    '{OpRead,  8'h00, 1'b0, NoStatus},
    '{OpWrite, 8'hfe, 1'b0, NoStatus},
    '{OpRead,  8'h00, 1'b0, NoStatus},
    '{OpRead,  8'h00, 1'b0, NoStatus},
    '{OpRead,  8'h00, 1'b0, NoStatus},
    '{OpRead,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0, 13'd0, 32'd0, 32'd0}}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        op_i = '0;
  logic [DataW-1:0]  data_byte_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DataW-1:0]  read_data_o;
  logic              read_valid_o;
  logic              overwrote_o;
  logic [FillW-1:0]  fill_level_o;
  logic [CountW-1:0] dropped_taken_o;
  logic [CountW-1:0] dropped_all_o;

  logic [DataW-1:0]  shadow_bytes [Depth];
  int unsigned       shadow_head = 0;
  int unsigned       shadow_tail = 0;
  int unsigned       shadow_used = 0;
  logic [CountW-1:0] shadow_drop_take = '0;
  logic [CountW-1:0] shadow_drop_all = '0;
  fifo_status_t      status_queue [$];

  fifo_status_t      got_status;
  fifo_status_t      want_status;
  int unsigned       fail_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       items_sent = 0;
  int unsigned       bytes_popped = 0;
  int unsigned       empty_reads = 0;
  int unsigned       overwrites = 0;
  int unsigned       takes = 0;
  int unsigned       peak_fill = 0;

  overwrite_oldest_byte_fifo u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .read_data_o     (read_data_o),
    .read_valid_o    (read_valid_o),
    .overwrote_o     (overwrote_o),
    .fill_level_o    (fill_level_o),
    .dropped_taken_o (dropped_taken_o),
    .dropped_all_o   (dropped_all_o)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic fifo_status_t fifo_apply(input op_e op, input logic [DataW-1:0] data);
    fifo_status_t st;
    st = '0;
    if (op == OpWrite) begin
      if (shadow_used == Depth) begin
        shadow_head = (shadow_head + 1) % Depth;
        shadow_used--;
        if (shadow_drop_take != '1) shadow_drop_take++;
        if (shadow_drop_all != '1) shadow_drop_all++;
        st.overwrote = 1'b1;
      end
      shadow_bytes[shadow_tail] = data;
      shadow_tail = (shadow_tail + 1) % Depth;
      shadow_used++;
    end else if (op == OpRead && shadow_used != 0) begin
      st.read_data  = shadow_bytes[shadow_head];
      st.read_valid = 1'b1;
      shadow_head = (shadow_head + 1) % Depth;
      shadow_used--;
    end
    st.dropped_taken = shadow_drop_take;
    if (op == OpTake) shadow_drop_take = '0;
    st.fill_level  = FillW'(shadow_used);
    st.dropped_all = shadow_drop_all;
    return st;
  endfunction

  task automatic send_item(input op_e op, input logic [DataW-1:0] data, input logic known,
                           input fifo_status_t typed);
    fifo_status_t st;
    int unsigned  gap;
    int unsigned  pick;
    gap = 0;
    if ((items_sent / 64) % 4 != 1) begin
      pick = $urandom_range(0, 99);
      if (pick >= 93) gap = $urandom_range(6, 30);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= data;
    do @(negedge clk_i); while (in_stall_o !== 1'b0);
    @(posedge clk_i);
    st = fifo_apply(op, data);
    status_queue.push_back(known ? typed : st);
    items_sent++;
    if (st.read_valid) bytes_popped++;
    if (op == OpRead && !st.read_valid) empty_reads++;
    if (st.overwrote) overwrites++;
    if (op == OpTake) takes++;
    if (shadow_used > peak_fill) peak_fill = shadow_used;
  endtask

  task automatic send_random(input int unsigned w_write, input int unsigned w_read,
                             input int unsigned w_take);
    int unsigned pick;
    op_e         op;
    pick = $urandom_range(0, 99);
    if (pick < w_write) op = OpWrite;
    else if (pick < w_write + w_read) op = OpRead;
    else if (pick < w_write + w_read + w_take) op = OpTake;
    else op = OpNop;
    send_item(op, DataW'($urandom), 1'b0, NoStatus);
  endtask

  task automatic wait_results_done();
    while (status_queue.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (Script[i]) begin
      send_item(Script[i].op, Script[i].data, Script[i].known, Script[i].status);
    end

    repeat (MixedItems) send_random(45, 35, 10);

    // hold off until every result is back
    in_valid_i <= 1'b0;
    wait_results_done();

    repeat (OverItems) send_random(86, 4, 6);
    repeat (DrainItems) send_random(10, 80, 5);
    repeat (MixedItems) send_random(35, 45, 10);

    in_valid_i <= 1'b0;
    wait_results_done();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d transfers: %0d bytes popped, %0d empty reads, %0d takes",
             items_sent, bytes_popped, empty_reads, takes);
    $display("store filled to %0d, %0d oldest bytes overwritten, %0d mismatches",
             peak_fill, overwrites, fail_count);
    if (fail_count == 0) begin
      $display("overwrite_oldest_byte_fifo verification clean");
    end else begin
      $display("overwrite_oldest_byte_fifo verification failed");
    end
    $finish;
  end

  initial begin : stall_driver
    int unsigned pick;
    int unsigned run;
    @(posedge rst_ni);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 8) run = $urandom_range(100, 200);
      else if (pick < 50) run = $urandom_range(1, 40);
      else if (pick < 92) run = $urandom_range(1, 3);
      else run = $urandom_range(5, 25);
      out_stall_i <= (pick >= 50);
      repeat (run) @(posedge clk_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_status = '{read_data_o, read_valid_o, overwrote_o, fill_level_o,
                     dropped_taken_o, dropped_all_o};
      if (status_queue.size() == 0) begin
        if (fail_count < ReportMax)
          $display("unexpected result transfer at cycle %0d: data %02h fill %0d",
                   cycle_count, got_status.read_data, got_status.fill_level);
        fail_count++;
      end else begin
        want_status = status_queue.pop_front();
        if (got_status.read_data !== want_status.read_data ||
            got_status.read_valid !== want_status.read_valid ||
            got_status.overwrote !== want_status.overwrote ||
            got_status.fill_level !== want_status.fill_level ||
            got_status.dropped_taken !== want_status.dropped_taken ||
            got_status.dropped_all !== want_status.dropped_all) begin
          if (fail_count < ReportMax) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  exp data %02h rv %0b ovr %0b fill %0d taken %0d all %0d",
                     want_status.read_data, want_status.read_valid, want_status.overwrote,
                     want_status.fill_level, want_status.dropped_taken,
                     want_status.dropped_all);
            $display("  got data %02h rv %0b ovr %0b fill %0d taken %0d all %0d",
                     got_status.read_data, got_status.read_valid, got_status.overwrote,
                     got_status.fill_level, got_status.dropped_taken,
                     got_status.dropped_all);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, status_queue.size());
      $display("overwrite_oldest_byte_fifo verification failed");
      $finish;
    end
  end

endmodule

`default_nettype wire
